// ----- rtl/fractional_feedback_delay_line_core_assert.svh -----
// Assertion macros for the fractional feedback delay line core.
// Included by the top level; depends on nothing else.
`ifndef FRACTIONAL_FEEDBACK_DELAY_LINE_CORE_ASSERT_SVH
`define FRACTIONAL_FEEDBACK_DELAY_LINE_CORE_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define FFDL_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("delay line check failed");

// The condition implies the expression in the next cycle.
`define FFDL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("delay line check failed");

`endif

// ----- rtl/ffdl_pkg.sv -----
// Shared constants, types and saturation helpers of the delay line core.
// No dependencies; imported by every module of the block.
package ffdl_pkg;

   // Store geometry.
   localparam int DELAY_DEPTH = 16384;
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);

   // Datapath widths.
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 17;
   localparam int OPER_W   = 18;
   localparam int PROD_W   = 2 * OPER_W;
   localparam int ROUND_W  = PROD_W - 16;

   localparam logic [GAIN_W-1:0] UNITY_Q16 = GAIN_W'(65536);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_INTEGER  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_FRACTION = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRY_WET_MIX    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLPASS_MODE   = 3'd5;

   typedef logic [ADDR_W-1:0] addr_type;

   // Control from the sequencer to the delay store.
   typedef struct packed {
      logic                       rd_en;
      addr_type                   rd_addr;
      logic                       wr_en;
      logic signed [SAMPLE_W-1:0] wr_data;
   } store_ctrl_type;

   // Control from the sequencer to the shared multiplier.
   typedef struct packed {
      logic                     load;
      logic signed [OPER_W-1:0] op_a;
      logic signed [OPER_W-1:0] op_b;
      logic signed [PROD_W-1:0] addend;
   } mac_ctrl_type;

   // Saturate a widened value to a 16 bit sample.
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ROUND_W:0] v);
      if (v > (ROUND_W+1)'(32767)) begin
         return SAMPLE_W'(32767);
      end else if (v < (ROUND_W+1)'(-32768)) begin
         return SAMPLE_W'(-32768);
      end
      return SAMPLE_W'(v);
   endfunction

   // Clamp a Q1.16 gain to unity.
   function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] g);
      return (g > UNITY_Q16) ? UNITY_Q16 : g;
   endfunction

endpackage

// ----- rtl/ffdl_mac.sv -----
// Shared multiplier of the delay line core with a registered product and rounding.
// Depends on ffdl_pkg.
module ffdl_mac import ffdl_pkg::*; (
   input  logic                      clock,
   input  mac_ctrl_type              ctrl,
   output logic signed [ROUND_W-1:0] rounded
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] sum;

   // One signed 18 by 18 multiply, held for the following step.
   assign prod_in = ctrl.op_a * ctrl.op_b;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   // Add the offset, then round to nearest with ties toward plus infinity.
   assign sum     = prod_ff + ctrl.addend + PROD_W'(32768);
   assign rounded = sum[PROD_W-1:16];

endmodule

// ----- rtl/ffdl_store.sv -----
// Circular sample store of the delay line core with write pointer and fill tracking.
// Depends on ffdl_pkg.
module ffdl_store import ffdl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  store_ctrl_type             ctrl,
   output addr_type                   wp,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic                       rvalid_ff;
   logic                       rvalid_in;
   addr_type                   wp_ff;
   addr_type                   wp_in;
   logic                       wrapped_ff;
   logic                       wrapped_in;

   // Memory array: one write at the pointer, one registered read.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wp_ff] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= mem[ctrl.rd_addr];
      end
   end

   // An entry holds data once the pointer has passed it since reset.
   assign rvalid_in = wrapped_ff || (ctrl.rd_addr < wp_ff);

   // Pointer advance with wrap at the store depth.
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (ctrl.wr_en) begin
         if (wp_ff == ADDR_W'(DELAY_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         rvalid_ff  <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         if (ctrl.rd_en) begin
            rvalid_ff <= rvalid_in;
         end
      end
   end

   // Entries never written read as zero.
   assign rd_data = rvalid_ff ? rdata_ff : '0;
   assign wp      = wp_ff;

endmodule

// ----- rtl/fractional_feedback_delay_line_core.sv -----
// Top level of the fractional feedback delay line: registers, sequencer and result stage.
// Depends on ffdl_pkg, ffdl_mac, ffdl_store and the assertion macro header.
//
//   Channel   Ports                                  Direction  Moves
//   req       req_valid, req_ready, req_sample_in    in         one Q1.15 sample request
//   rsp       rsp_valid, rsp_ready, rsp_sample_out   out        one Q1.15 result sample
//   csr       csr_wen, csr_index, csr_wdata          in         one register write
//
// In echo mode a request goes from acceptance to a loaded result through two reads on the
// single store port, four multiplier passes and one write; in all-pass mode three passes.
// The sequencer is idle from the loading edge on, ready for the next request from then on.
// req_ready is high only while the sequencer is idle; a result waiting in the output register
// does not block the next request until its final step.
// Synchronous reset clears pointer, fill tracking and state, presets CSRs; no clearing pass.
`include "fractional_feedback_delay_line_core_assert.svh"

module fractional_feedback_delay_line_core import ffdl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                         csr_wen,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'h0001,
      ST_RD_A  = 13'h0002,
      ST_RD_B  = 13'h0004,
      ST_DIFF  = 13'h0008,
      ST_MUL_F = 13'h0010,
      ST_TAP   = 13'h0020,
      ST_MUL_G = 13'h0040,
      ST_FIRST = 13'h0080,
      ST_MUL2  = 13'h0100,
      ST_STORE = 13'h0200,
      ST_MUL3  = 13'h0400,
      ST_MIX   = 13'h0800,
      ST_OUT   = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [13:0]       delay_integer_ff;
   logic [15:0]       delay_fraction_ff;
   logic [GAIN_W-1:0] decay_gain_ff;
   logic [GAIN_W-1:0] feedback_gain_ff;
   logic [GAIN_W-1:0] dry_wet_mix_ff;
   logic              allpass_mode_ff;

   // Per-request working registers.
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   addr_type                   rd_ff, rd_in;
   addr_type                   older_ff, older_in;
   logic                       dzero_ff, dzero_in;
   logic signed [SAMPLE_W-1:0] a_ff, a_in;
   logic signed [SAMPLE_W:0]   diff_ff, diff_in;
   logic signed [SAMPLE_W-1:0] tap_ff, tap_in;
   logic signed [SAMPLE_W-1:0] v_ff, v_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   store_ctrl_type             store_ctrl;
   mac_ctrl_type               mac_ctrl;
   addr_type                   wp;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic signed [ROUND_W-1:0]  rounded;

   logic [31:0]                d_wide;
   addr_type                   d_eff;
   logic [ADDR_W:0]            wrap_sum;
   addr_type                   rd_calc;
   addr_type                   older_calc;
   logic [GAIN_W-1:0]          g_clamped;
   logic [GAIN_W-1:0]          fb_clamped;
   logic [GAIN_W-1:0]          mix_clamped;
   logic signed [ROUND_W:0]    x_plus_r;
   logic signed [ROUND_W:0]    x_minus_r;
   logic signed [ROUND_W:0]    tap_plus_r;
   logic signed [ROUND_W-1:0]  a_plus_r;
   logic                       out_fire;

   ffdl_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .wp      (wp),
      .rd_data (rd_data)
   );

   ffdl_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .rounded (rounded)
   );

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_integer_ff  <= '0;
         delay_fraction_ff <= '0;
         decay_gain_ff     <= UNITY_Q16;
         feedback_gain_ff  <= '0;
         dry_wet_mix_ff    <= UNITY_Q16;
         allpass_mode_ff   <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_DELAY_INTEGER:  delay_integer_ff  <= csr_wdata[13:0];
            CSR_DELAY_FRACTION: delay_fraction_ff <= csr_wdata[15:0];
            CSR_DECAY_GAIN:     decay_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_FEEDBACK_GAIN:  feedback_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_DRY_WET_MIX:    dry_wet_mix_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_ALLPASS_MODE:   allpass_mode_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Tap address: clamp the delay, then step back from the write pointer.
   assign d_wide   = 32'(delay_integer_ff);
   assign d_eff    = (d_wide > 32'(DELAY_DEPTH - 1)) ? ADDR_W'(DELAY_DEPTH - 1)
                                                      : ADDR_W'(d_wide);
   assign wrap_sum = {1'b0, wp} + (ADDR_W+1)'(DELAY_DEPTH) - {1'b0, d_eff};
   assign rd_calc  = (wp >= d_eff) ? (wp - d_eff) : wrap_sum[ADDR_W-1:0];
   assign older_calc = (rd_ff == '0) ? ADDR_W'(DELAY_DEPTH - 1) : (rd_ff - 1'b1);

   // Gains limited to unity.
   assign g_clamped   = gain_clamp(decay_gain_ff);
   assign fb_clamped  = gain_clamp(feedback_gain_ff);
   assign mix_clamped = gain_clamp(dry_wet_mix_ff);

   // Sums around the rounded product.
   assign x_plus_r   = (ROUND_W+1)'(x_ff) + (ROUND_W+1)'(rounded);
   assign x_minus_r  = (ROUND_W+1)'(x_ff) - (ROUND_W+1)'(rounded);
   assign tap_plus_r = (ROUND_W+1)'(tap_ff) + (ROUND_W+1)'(rounded);
   assign a_plus_r   = ROUND_W'(a_ff) + rounded;

   assign out_fire = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer and datapath steps.
   always_comb begin
      state_in          = state_ff;
      x_in              = x_ff;
      rd_in             = rd_ff;
      older_in          = older_ff;
      dzero_in          = dzero_ff;
      a_in              = a_ff;
      diff_in           = diff_ff;
      tap_in            = tap_ff;
      v_in              = v_ff;
      y_in              = y_ff;
      store_ctrl        = '0;
      mac_ctrl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               rd_in    = rd_calc;
               dzero_in = (d_eff == '0);
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            store_ctrl.rd_en   = 1'b1;
            store_ctrl.rd_addr = rd_ff;
            older_in           = older_calc;
            state_in           = ST_RD_B;
         end
         ST_RD_B: begin
            // With zero delay the tap is the current input itself.
            store_ctrl.rd_en   = 1'b1;
            store_ctrl.rd_addr = older_ff;
            a_in               = dzero_ff ? x_ff : rd_data;
            state_in           = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = (SAMPLE_W+1)'(rd_data) - (SAMPLE_W+1)'(a_ff);
            state_in = ST_MUL_F;
         end
         ST_MUL_F: begin
            mac_ctrl.load = 1'b1;
            mac_ctrl.op_a = OPER_W'(diff_ff);
            mac_ctrl.op_b = $signed({2'b00, delay_fraction_ff});
            state_in      = ST_TAP;
         end
         ST_TAP: begin
            // The interpolated value lies between the two entries.
            tap_in   = a_plus_r[SAMPLE_W-1:0];
            state_in = ST_MUL_G;
         end
         ST_MUL_G: begin
            mac_ctrl.load = 1'b1;
            mac_ctrl.op_a = OPER_W'(tap_ff);
            mac_ctrl.op_b = $signed({1'b0, g_clamped});
            state_in      = ST_FIRST;
         end
         ST_FIRST: begin
            // Wet signal in echo mode, the stored value in all-pass mode.
            if (allpass_mode_ff) begin
               v_in = sat16(x_minus_r);
            end else begin
               v_in = sat16((ROUND_W+1)'(rounded));
            end
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mac_ctrl.load = 1'b1;
            mac_ctrl.op_a = OPER_W'(v_ff);
            mac_ctrl.op_b = allpass_mode_ff ? $signed({1'b0, g_clamped})
                                            : $signed({1'b0, fb_clamped});
            state_in      = ST_STORE;
         end
         ST_STORE: begin
            store_ctrl.wr_en = 1'b1;
            if (dzero_ff) begin
               store_ctrl.wr_data = x_ff;
            end else if (allpass_mode_ff) begin
               store_ctrl.wr_data = v_ff;
            end else begin
               store_ctrl.wr_data = sat16(x_plus_r);
            end
            if (allpass_mode_ff) begin
               y_in     = sat16(tap_plus_r);
               state_in = ST_OUT;
            end else begin
               diff_in  = (SAMPLE_W+1)'(v_ff) - (SAMPLE_W+1)'(x_ff);
               state_in = ST_MUL3;
            end
         end
         ST_MUL3: begin
            // x*(1-mix) + wet*mix is formed as x*unity + (wet-x)*mix.
            mac_ctrl.load = 1'b1;
            mac_ctrl.op_a = OPER_W'(diff_ff);
            mac_ctrl.op_b = $signed({1'b0, mix_clamped});
            state_in      = ST_MIX;
         end
         ST_MIX: begin
            mac_ctrl.addend = PROD_W'(x_ff) <<< 16;
            y_in            = sat16((ROUND_W+1)'(rounded));
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (out_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register, loaded once the previous result has been taken.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_fire) begin
         rsp_data_in  = y_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      rd_ff       <= rd_in;
      older_ff    <= older_in;
      dzero_ff    <= dzero_in;
      a_ff        <= a_in;
      diff_ff     <= diff_in;
      tap_ff      <= tap_in;
      v_ff        <= v_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // An accepted request starts the read sequence and closes the input.
   `FFDL_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_RD_A && !req_ready)
   // Each store write moves the write pointer.
   `FFDL_ASSERT_NEXT(a_write_advances, clock, reset, store_ctrl.wr_en, wp != $past(wp))
   // With zero delay the tap address is the write position.
   `FFDL_ASSERT_NOW(a_zero_delay_tap, clock, reset, state_ff == ST_RD_B && dzero_ff, rd_ff == wp)
   // The final step always presents a result and frees the sequencer.
   `FFDL_ASSERT_NEXT(a_result_loaded, clock, reset, out_fire, rsp_valid && state_ff == ST_IDLE)

endmodule
